@@ hdl/csq_pkg.sv @@
// Package for the counting semaphore with a first-in first-out wait queue.
// Holds the request and result codes, the state type and the queue control struct.
// Depends on nothing; every other file imports it.
`default_nettype none

package csq_pkg;

    // Width of the configured starting count and of the signed count.
    localparam int INIT_W  = 15;
    localparam int COUNT_W = 17;
    localparam int KIND_W  = 3;
    localparam int REQ_W   = 2;

    // Largest count; a signal at this value saturates.
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 17'sd65535;

    // Request codes. The fourth code carries no meaning and is ignored.
    localparam logic [REQ_W-1:0] REQ_WAIT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SIGNAL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_PROCEED       = 3'd0,
        KIND_BLOCKED       = 3'd1,
        KIND_WOKEN_SIGNAL  = 3'd2,
        KIND_WOKEN_RELEASE = 3'd3,
        KIND_NO_WAKE       = 3'd4,
        KIND_QUEUE_FULL    = 3'd5,
        KIND_RELEASE_EMPTY = 3'd6,
        KIND_PANIC         = 3'd7
    } csq_kind_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } csq_state_t;

    // Commands from the controller to the row of queue cells.
    typedef struct packed {
        logic push;
        logic pop;
    } csq_qctl_t;

endpackage

`default_nettype wire

@@ hdl/csq_req_if.sv @@
// Request channel: request type and calling thread id with valid and ready.
// Depends on csq_pkg.
`default_nettype none

interface csq_req_if
    import csq_pkg::*;
#(
    parameter int THREAD_ID_BITS = 8
);
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [THREAD_ID_BITS-1:0] thread_id;

    modport source (output valid, output req_type, output thread_id, input ready);
    modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

`default_nettype wire

@@ hdl/csq_rsp_if.sv @@
// Result channel: result kind, thread id, wake return and last flag with valid and ready.
// Depends on csq_pkg.
`default_nettype none

interface csq_rsp_if
    import csq_pkg::*;
#(
    parameter int THREAD_ID_BITS = 8
);
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [THREAD_ID_BITS-1:0] thread_id_out;
    logic signed [0:0]         wake_return;
    logic                      last;

    modport source (output valid, output kind, output thread_id_out,
                    output wake_return, output last, input ready);
    modport sink   (input valid, input kind, input thread_id_out,
                    input wake_return, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/csq_cfg_if.sv @@
// Configuration write channel carrying the starting count with valid and ready.
// Depends on csq_pkg.
`default_nettype none

interface csq_cfg_if
    import csq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [INIT_W-1:0] initial_value;

    modport source (output valid, output initial_value, input ready);
    modport sink   (input valid, input initial_value, output ready);
endinterface

`default_nettype wire

@@ hdl/csq_cell.sv @@
// One cell of the wait queue: holds one thread id and hands it to its lower neighbour on a pop.
// Depends on csq_pkg.
`default_nettype none

module csq_cell
    import csq_pkg::*;
#(
    parameter int TID_W = 8,
    parameter int OCC_W = 5,
    parameter int IDX   = 0
)
(
    input  wire logic             clk,
    input  wire csq_qctl_t        qctl,
    input  wire logic [OCC_W-1:0] occupancy,
    input  wire logic [TID_W-1:0] push_id,
    input  wire logic [TID_W-1:0] upper_id,
    output logic      [TID_W-1:0] id
);

    logic [TID_W-1:0] id_reg;
    logic [TID_W-1:0] id_next;

    // A pop shifts the row down by one; a push fills the first free cell.
    always_comb
    begin
        id_next = id_reg;
        if (qctl.pop)
        begin
            id_next = upper_id;
        end
        else if (qctl.push && (occupancy == OCC_W'(IDX)))
        begin
            id_next = push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

@@ hdl/csq_chain.sv @@
// Row of queue cells with the fill count; the oldest waiter always sits in cell zero.
// Depends on csq_pkg and csq_cell.
`default_nettype none

module csq_chain
    import csq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int TID_W = 8,
    parameter int OCC_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire csq_qctl_t        qctl,
    input  wire logic [TID_W-1:0] push_id,
    output logic      [TID_W-1:0] head_id,
    output logic      [OCC_W-1:0] occupancy,
    output logic                  empty,
    output logic                  full,
    output logic                  one_left
);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [TID_W-1:0] cell_id [DEPTH];

    // Fill count follows pushes and pops.
    always_comb
    begin
        occ_next = occ_reg;
        if (qctl.push)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (qctl.pop)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The row of cells; the top cell keeps its own value on a pop.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TID_W-1:0] upper;
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_id[i];
        end
        else
        begin : g_mid
            assign upper = cell_id[i+1];
        end
        csq_cell #(
            .TID_W (TID_W),
            .OCC_W (OCC_W),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .qctl      (qctl),
            .occupancy (occ_reg),
            .push_id   (push_id),
            .upper_id  (upper),
            .id        (cell_id[i])
        );
    end

    assign head_id   = cell_id[0];
    assign occupancy = occ_reg;
    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == OCC_W'(DEPTH));
    assign one_left  = (occ_reg == OCC_W'(1));

    // A pop never meets an empty row, nor a push a full one.
    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop |-> !empty)
        else $error("pop from an empty wait queue");
    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> !full)
        else $error("push into a full wait queue");
    a_one_op : assert property (@(posedge clk) disable iff (!rst_n)
        !(qctl.push && qctl.pop))
        else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

@@ hdl/counting_semaphore_wait_queue.sv @@
// Counting semaphore with a first-in first-out queue of blocked thread ids.
// Result words are registered. A release with waiters first enters the drain state, which then
// loads its words; wait and signal requests are taken back to back while the output is free.
// A release with waiters holds the input while one waiter leaves the row per cycle, unless the output stalls.
// Reset: count 0, starting count 0, queue empty, no result pending. Output stalls hold.
// Depends on csq_pkg, the channel interfaces, csq_chain and csq_cell.
`default_nettype none

module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    csq_req_if.sink    req,
    csq_rsp_if.source  rsp,
    csq_cfg_if.sink    cfg
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TID_W = THREAD_ID_BITS;

    csq_state_t                  state_reg;
    csq_state_t                  state_next;
    logic [INIT_W-1:0]           init_reg;
    logic signed [COUNT_W-1:0]   count_reg;
    logic signed [COUNT_W-1:0]   count_next;
    logic signed [COUNT_W-1:0]   count_init;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    csq_kind_t                   kind_reg;
    csq_kind_t                   kind_next;
    logic [TID_W-1:0]            tid_reg;
    logic [TID_W-1:0]            tid_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic                        last_reg;
    logic                        last_next;
    logic                        emit;
    logic                        out_free;
    logic                        in_fire;
    csq_qctl_t                   qctl;
    logic [TID_W-1:0]            head_id;
    logic [OCC_W-1:0]            occupancy;
    logic                        q_empty;
    logic                        q_full;
    logic                        q_one;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire    = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign count_init = $signed({{(COUNT_W-INIT_W){1'b0}}, init_reg});

    // Starting count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
        end
        else if (cfg.valid)
        begin
            init_reg <= cfg.initial_value;
        end
    end

    // Next state: a release with waiters drains them one per cycle while the output is not stalled.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req.req_type == REQ_RELEASE) && !q_empty)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free && q_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Count update, queue commands and the next result word.
    always_comb
    begin
        count_next = count_reg;
        qctl       = '{push: 1'b0, pop: 1'b0};
        emit       = 1'b0;
        kind_next  = kind_reg;
        tid_next   = tid_reg;
        neg_next   = 1'b0;
        last_next  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    tid_next = '0;
                    case (req.req_type)
                        REQ_WAIT:
                        begin
                            emit     = 1'b1;
                            tid_next = req.thread_id;
                            if (count_reg <= 0)
                            begin
                                if (q_full)
                                begin
                                    kind_next = KIND_QUEUE_FULL;
                                end
                                else
                                begin
                                    kind_next  = KIND_BLOCKED;
                                    count_next = count_reg - COUNT_W'(1);
                                    qctl.push  = 1'b1;
                                end
                            end
                            else
                            begin
                                kind_next  = KIND_PROCEED;
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                        REQ_SIGNAL:
                        begin
                            emit = 1'b1;
                            if (count_reg >= COUNT_MAX)
                            begin
                                kind_next  = KIND_NO_WAKE;
                                count_next = COUNT_MAX;
                            end
                            else
                            begin
                                count_next = count_reg + COUNT_W'(1);
                                if (count_reg < 0)
                                begin
                                    if (q_empty)
                                    begin
                                        kind_next = KIND_PANIC;
                                    end
                                    else
                                    begin
                                        kind_next = KIND_WOKEN_SIGNAL;
                                        tid_next  = head_id;
                                        qctl.pop  = 1'b1;
                                    end
                                end
                                else
                                begin
                                    kind_next = KIND_NO_WAKE;
                                end
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (q_empty)
                            begin
                                emit       = 1'b1;
                                kind_next  = KIND_RELEASE_EMPTY;
                                count_next = count_init;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    qctl.pop  = 1'b1;
                    kind_next = KIND_WOKEN_RELEASE;
                    tid_next  = head_id;
                    neg_next  = 1'b1;
                    last_next = q_one;
                    if (q_one)
                    begin
                        count_next = count_init;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Output word register: loaded on a new result, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            tid_reg  <= tid_next;
            neg_reg  <= neg_next;
            last_reg <= last_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = kind_reg;
    assign rsp.thread_id_out = tid_reg;
    assign rsp.wake_return   = neg_reg;
    assign rsp.last          = last_reg;

    // Row of queue cells.
    csq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .TID_W (TID_W),
        .OCC_W (OCC_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .qctl      (qctl),
        .push_id   (req.thread_id),
        .head_id   (head_id),
        .occupancy (occupancy),
        .empty     (q_empty),
        .full      (q_full),
        .one_left  (q_one)
    );

    // While idle with waiters queued, the count is minus the number of waiters.
    a_count_tracks_queue : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !q_empty)
            |-> (count_reg == -$signed({{(COUNT_W-OCC_W){1'b0}}, occupancy})))
        else $error("count does not match the number of queued waiters");
    a_drain_has_waiters : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !q_empty)
        else $error("draining with an empty wait queue");
    a_drain_reloads : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && (state_next == ST_IDLE))
            |=> (count_reg == count_init) && q_empty)
        else $error("count not reloaded at the end of a release");

endmodule

`default_nettype wire
